// ----- rtl/core/tsplb_pkg.sv -----
// Package for the partial-tour lower bound block: field widths, command codes,
// the queued request type and the back-end sequencer states.
// No dependencies.
package tsplb_pkg;

  localparam int COST_W  = 16;
  localparam int MASK_W  = 16;
  localparam int CITY_W  = 4;
  localparam int PATH_W  = 20;
  localparam int BOUND_W = 23;
  localparam int COUNT_W = 5;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [COUNT_W-1:0] CITY_COUNT_RESET = 5'd16;
  localparam logic [BOUND_W-1:0] BOUND_TOP        = 23'd4194303;

  // depth of the queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;

  // one classified request as it waits in the queue
  typedef struct packed {
    logic              is_query;
    logic              tail_ok;
    logic [CITY_W-1:0] row_city;
    logic [CITY_W-1:0] column_city;
    logic [COST_W-1:0] edge_cost;
    logic [MASK_W-1:0] visited_mask;
    logic [CITY_W-1:0] tail_city;
    logic [PATH_W-1:0] path_cost;
  } item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_NEXT,
    BK_SCAN,
    BK_ROW_END,
    BK_FINAL
  } back_state_t;

endpackage

// ----- rtl/core/tsplb_front.sv -----
// Front end: takes requests, decodes the command, drops cost writes outside
// the table, and holds classified requests in a short queue. Uses tsplb_pkg.
module tsplb_front import tsplb_pkg::*; #(
  parameter int MAX_CITIES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              command,
  input  logic [CITY_W-1:0] row_city,
  input  logic [CITY_W-1:0] column_city,
  input  logic [COST_W-1:0] edge_cost,
  input  logic [MASK_W-1:0] visited_mask,
  input  logic [CITY_W-1:0] tail_city,
  input  logic [PATH_W-1:0] path_cost,
  output logic              q_valid,
  output item_t             q_item,
  input  logic              q_ready
);

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  item_t          slots [QUEUE_DEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QCW-1:0] count;

  item_t cls_item;
  logic  accept;
  logic  keep;
  logic  enq;
  logic  deq;
  logic  write_in_range;

  // classify the incoming request
  always_comb begin
    write_in_range = (7'(row_city) < 7'(MAX_CITIES)) && (7'(column_city) < 7'(MAX_CITIES));
    cls_item.is_query     = (command == CMD_QUERY);
    cls_item.tail_ok      = (7'(tail_city) < 7'(MAX_CITIES));
    cls_item.row_city     = row_city;
    cls_item.column_city  = column_city;
    cls_item.edge_cost    = edge_cost;
    cls_item.visited_mask = visited_mask;
    cls_item.tail_city    = tail_city;
    cls_item.path_cost    = path_cost;
    keep = cls_item.is_query || write_in_range;
  end

  assign full    = (count == QCW'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = slots[rptr];
  assign accept  = push && !full;
  assign enq     = accept && keep;
  assign deq     = q_valid && q_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wptr] <= cls_item;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (enq) begin
        wptr <= wptr + QAW'(1);
      end
      if (deq) begin
        rptr <= rptr + QAW'(1);
      end
      case ({enq, deq})
        2'b10:   count <= count + QCW'(1);
        2'b01:   count <= count - QCW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/tsplb_back.sv -----
// Back end: owns the cost table memory, performs writes, and scans the table
// one entry a cycle within each row to build the bound, then holds it in the
// output register. Uses tsplb_pkg.
module tsplb_back import tsplb_pkg::*; #(
  parameter int MAX_CITIES = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [COUNT_W-1:0]        city_count,
  input  logic                      q_valid,
  input  item_t                     q_item,
  output logic                      q_ready,
  output logic                      empty,
  input  logic                      pop,
  output logic signed [BOUND_W-1:0] bound_value
);

  localparam int CW   = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam int CNTW = $clog2(MAX_CITIES + 1);
  localparam int AW   = 2 * CW;
  localparam longint ACC_MAX = 64'(2 ** PATH_W - 1) + 64'(MAX_CITIES) * 64'(2 ** COST_W - 1);
  localparam int ACCW_RAW = $clog2(ACC_MAX + 1);
  localparam int ACCW     = (ACCW_RAW > BOUND_W) ? ACCW_RAW : BOUND_W;

  back_state_t state;
  back_state_t state_next;

  logic [COST_W-1:0]     mem [2 ** AW];
  logic [COST_W-1:0]     rd_data;
  logic                  rd_vld;
  logic                  rd_elig;

  logic [CNTW-1:0]       row;
  logic [CNTW-1:0]       col;
  logic                  is_tail;
  logic                  tail_none;
  logic [MAX_CITIES-1:0] rest;
  logic [MAX_CITIES-1:0] rest_new;
  logic [ACCW-1:0]       acc;
  logic [COST_W-1:0]     row_min;
  logic                  found;
  logic                  out_valid;
  logic [BOUND_W-1:0]    bound_reg;

  logic [CNTW-1:0]       n_eff;
  logic                  n_lt2;
  logic [CW-1:0]         row_ix;
  logic [CW-1:0]         col_ix;
  logic                  elig;
  logic                  col_last;
  logic                  row_done;
  logic                  take;
  logic                  mem_we;
  logic                  start;
  logic                  issue;
  logic                  out_load;
  logic                  better;
  logic                  better_last;
  logic [COST_W-1:0]     min_fin;
  logic                  found_fin;
  logic [ACCW-1:0]       acc_dec;
  logic [BOUND_W-1:0]    final_val;
  logic [AW-1:0]         raddr;
  logic [AW-1:0]         waddr;

  // cities in use, clipped to the table size
  assign n_eff = (7'(city_count) > 7'(MAX_CITIES)) ? CNTW'(MAX_CITIES) : CNTW'(city_count);
  assign n_lt2 = (n_eff < CNTW'(2));

  // remaining-city set for the request at the queue head
  for (genvar g = 0; g < MAX_CITIES; g++) begin : g_rest
    if (g == 0) begin : g_start
      assign rest_new[g] = 1'b0;
    end else if (g < MASK_W) begin : g_masked
      assign rest_new[g] = (CNTW'(g) < n_eff) && !q_item.visited_mask[g];
    end else begin : g_unmasked
      assign rest_new[g] = (CNTW'(g) < n_eff);
    end
  end

  // scan position and column eligibility
  always_comb begin
    row_ix   = row[CW-1:0];
    col_ix   = col[CW-1:0];
    col_last = (col == n_eff - CNTW'(1));
    row_done = (row >= n_eff);
    elig     = (!is_tail && (col == '0)) || (rest[col_ix] && (col_ix != row_ix));
    raddr    = {row_ix, col_ix};
    waddr    = {CW'(q_item.row_city), CW'(q_item.column_city)};
  end

  // running minimum of the current row
  always_comb begin
    better      = rd_vld && rd_elig && (!found || (rd_data < row_min));
    better_last = rd_elig && (!found || (rd_data < row_min));
    min_fin     = better_last ? rd_data : row_min;
    found_fin   = found || rd_elig;
  end

  // final correction and saturation
  always_comb begin
    acc_dec = acc - ACCW'(1);
    if (tail_none && (acc == '0)) begin
      final_val = '1;
    end else if (tail_none) begin
      final_val = (acc_dec > ACCW'(BOUND_TOP)) ? BOUND_TOP : acc_dec[BOUND_W-1:0];
    end else begin
      final_val = (acc > ACCW'(BOUND_TOP)) ? BOUND_TOP : acc[BOUND_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid && q_item.is_query) begin
          if (n_lt2) begin
            state_next = BK_FINAL;
          end else if (q_item.tail_ok) begin
            state_next = BK_SCAN;
          end else begin
            state_next = BK_NEXT;
          end
        end
      end
      BK_NEXT: begin
        if (row_done) begin
          state_next = BK_FINAL;
        end else if (rest[row_ix]) begin
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (col_last) begin
          state_next = BK_ROW_END;
        end
      end
      BK_ROW_END: state_next = BK_NEXT;
      BK_FINAL: begin
        if (!out_valid || pop) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_ready  = (state == BK_IDLE);
    take     = q_ready && q_valid;
    mem_we   = take && !q_item.is_query;
    start    = take && q_item.is_query;
    issue    = (state == BK_SCAN);
    out_load = (state == BK_FINAL) && (!out_valid || pop);
  end

  // cost table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= q_item.edge_cost;
    end
    rd_data <= mem[raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    rd_elig <= elig;
    unique case (state)
      BK_IDLE: begin
        if (start) begin
          rest      <= rest_new;
          acc       <= ACCW'(q_item.path_cost);
          is_tail   <= q_item.tail_ok;
          tail_none <= n_lt2 || !q_item.tail_ok;
          row       <= q_item.tail_ok ? CNTW'(q_item.tail_city) : CNTW'(1);
          col       <= '0;
          found     <= 1'b0;
        end
      end
      BK_NEXT: begin
        if (!row_done && rest[row_ix]) begin
          col   <= '0;
          found <= 1'b0;
        end else if (!row_done) begin
          row <= row + CNTW'(1);
        end
      end
      BK_SCAN: begin
        col <= col + CNTW'(1);
        if (better) begin
          row_min <= rd_data;
          found   <= 1'b1;
        end
      end
      BK_ROW_END: begin
        if (!is_tail || found_fin) begin
          acc <= acc + ACCW'(min_fin);
        end
        if (is_tail) begin
          // tail row done: if no city of the rest set is reachable, set tail_none
          if (!found_fin) begin
            tail_none <= 1'b1;
          end
          is_tail <= 1'b0;
          row     <= CNTW'(1);
        end else begin
          row <= row + CNTW'(1);
        end
      end
      BK_FINAL: begin
        if (out_load) begin
          bound_reg <= final_val;
        end
      end
      default: ;
    endcase
  end

  assign empty       = !out_valid;
  assign bound_value = signed'(bound_reg);

  // columns stay inside the cities in use
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (state == BK_SCAN) |-> (col < n_eff))
    else $error("scan column beyond city count");

  // a city row always has its return to city 0
  a_city_row_found: assert property (@(posedge clk) disable iff (rst)
    (state == BK_ROW_END && !is_tail) |-> (found || rd_elig))
    else $error("city row closed without a candidate");

  // each row starts with a cleared minimum
  a_scan_fresh: assert property (@(posedge clk) disable iff (rst)
    (state == BK_SCAN && $past(state) != BK_SCAN) |-> !found)
    else $error("row scan started with stale minimum");

  // the running sum only grows at row ends
  a_acc_grows: assert property (@(posedge clk) disable iff (rst)
    (state == BK_ROW_END) |=> (acc >= $past(acc)))
    else $error("bound sum decreased");

endmodule

// ----- rtl/core/tsp_partial_tour_lower_bound_top.sv -----
// Top level of the partial-tour lower bound block: city count register,
// front end with request queue, back end with cost table and scan sequencer.
// Uses tsplb_pkg, tsplb_front, tsplb_back.
//
//  channel   | handshake        | payload
//  ----------+------------------+----------------------------------------------
//  request   | push / full      | command, row_city, column_city, edge_cost,
//            |                  | visited_mask, tail_city, path_cost
//  result    | empty / pop      | bound_value
//  config    | cfg_write        | cfg_data (city_count)
//
// Cost writes are performed by the back end; writes outside the table are
// dropped at the front. A query scans the tail row, if tail_city is valid,
// and the rows of the remaining cities through the single read port of the
// cost table, one entry per cycle while a row is scanned.
// The two-entry queue takes new requests while a query scans; a result waits
// in the output register until popped, stalling only the back end.
// rst is synchronous; it empties the queue and output and sets city_count to 16.
module tsp_partial_tour_lower_bound_top import tsplb_pkg::*; #(
  parameter int MAX_CITIES = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic                      command,
  input  logic [CITY_W-1:0]         row_city,
  input  logic [CITY_W-1:0]         column_city,
  input  logic [COST_W-1:0]         edge_cost,
  input  logic [MASK_W-1:0]         visited_mask,
  input  logic [CITY_W-1:0]         tail_city,
  input  logic [PATH_W-1:0]         path_cost,
  output logic                      empty,
  input  logic                      pop,
  output logic signed [BOUND_W-1:0] bound_value,
  input  logic                      cfg_write,
  input  logic [COUNT_W-1:0]        cfg_data
);

  logic [COUNT_W-1:0] city_count;
  logic               q_valid;
  logic               q_ready;
  item_t              q_item;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      city_count <= CITY_COUNT_RESET;
    end else if (cfg_write) begin
      city_count <= cfg_data;
    end
  end

  tsplb_front #(
    .MAX_CITIES (MAX_CITIES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .command      (command),
    .row_city     (row_city),
    .column_city  (column_city),
    .edge_cost    (edge_cost),
    .visited_mask (visited_mask),
    .tail_city    (tail_city),
    .path_cost    (path_cost),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_ready      (q_ready)
  );

  tsplb_back #(
    .MAX_CITIES (MAX_CITIES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .city_count  (city_count),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_ready     (q_ready),
    .empty       (empty),
    .pop         (pop),
    .bound_value (bound_value)
  );

endmodule
